### hdl/grid_connectivity_map_unit_defines.svh
// Assertion macros used by the checker file of the grid connectivity map unit.
`ifndef GRID_CONNECTIVITY_MAP_UNIT_DEFINES_SVH
`define GRID_CONNECTIVITY_MAP_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define GCMU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define GCMU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/gcmu_pkg.sv
// Types, codes and neighbour tables for the grid connectivity map unit.
package gcmu_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam int COORD_W    = 6;
    localparam int DIR_W      = 8;
    localparam int DIM_W      = 7;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int NBR_COUNT = 8;

    localparam logic [DIR_W-1:0] MASK_ALL  = 8'hFF;
    localparam logic [DIR_W-1:0] MASK_NONE = 8'h00;
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef enum logic [2:0] {
        FUNC_OPEN,
        FUNC_CLOSE,
        FUNC_OR_MASK,
        FUNC_CLR_MASK,
        FUNC_SET_WALK,
        FUNC_READ,
        FUNC_FILL_ALL,
        FUNC_CLEAR_ALL
    } func_t;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH,
        REG_GRID_HEIGHT,
        REG_ALLOW_DIAG
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_TGT,
        ST_NBR,
        ST_WB,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        STEP_ZERO,
        STEP_DEC,
        STEP_INC
    } step_t;

    // Neighbour order: left, right, up, down, NW, NE, SW, SE
    localparam step_t NBR_DX [NBR_COUNT] = '{STEP_DEC, STEP_INC, STEP_ZERO, STEP_ZERO,
                                             STEP_DEC, STEP_INC, STEP_DEC, STEP_INC};
    localparam step_t NBR_DY [NBR_COUNT] = '{STEP_ZERO, STEP_ZERO, STEP_DEC, STEP_INC,
                                             STEP_DEC, STEP_DEC, STEP_INC, STEP_INC};
    localparam logic [DIR_W-1:0] NBR_OWN [NBR_COUNT] = '{8'h01, 8'h02, 8'h04, 8'h08,
                                                         8'h10, 8'h20, 8'h40, 8'h80};
    localparam logic [DIR_W-1:0] NBR_BACK [NBR_COUNT] = '{8'h02, 8'h01, 8'h08, 8'h04,
                                                          8'h80, 8'h40, 8'h20, 8'h10};
    localparam logic [NBR_COUNT-1:0] NBR_DIAG = 8'hF0;

endpackage

### hdl/grid_connectivity_map_unit.sv
// Navigation grid store: move masks and walkable bits per cell, with neighbour linking.
//
// Every item accepted on the s_ channel yields exactly one result item on the m_ channel:
// the target cell's move mask and walkable bit after the operation, or a coordinate error
// flag with zeros when the cell lies outside the configured grid. Cell state sits in two
// memories (8-bit masks, walkable bits), each with one write port and one registered read
// port. The unit handles one item at a time. Open and close run a nine-step neighbour
// sequence in which each step reads one neighbour and writes back the one read before;
// each result enters the output register as the unit returns to idle and can take the
// next item. Fill all and clear all rewrite every mask entry, one per cycle. After reset
// an initialisation pass over every entry loads every mask with 0xFF and every walkable
// bit with one; s_tready stays low until it ends, while configuration writes are taken
// as ever. A finished result waits in the output register, and the next item is accepted
// meanwhile. Grid size registers of zero count as one, and sizes above MAX_COLS or
// MAX_ROWS saturate to them.
module grid_connectivity_map_unit
    import gcmu_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input item channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // from bit 0: func[2:0], cell_x[5:0], cell_y[5:0], dir_bits[7:0], walk_value
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // result item channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // from bit 0: cell_mask[7:0], cell_walkable, coord_error, six zero bits
    output logic [M_TDATA_W-1:0]  m_tdata,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int XW    = $clog2(MAX_COLS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int KW    = $clog2(NBR_COUNT + 1);

    // True when a coordinate lies below both the configured size and the given limit
    function automatic logic dim_ok(input logic [DIM_W-1:0] c,
                                    input logic [DIM_W-1:0] used,
                                    input int limit);
        return (c < used) && (int'(c) < limit);
    endfunction

    function automatic logic [DIM_W-1:0] step_coord(input logic [DIM_W-1:0] c,
                                                    input step_t s);
        logic [DIM_W-1:0] r;
        case (s)
            STEP_DEC: r = c - 1'b1;
            STEP_INC: r = c + 1'b1;
            default:  r = c;
        endcase
        return r;
    endfunction

    function automatic logic step_ok(input logic [DIM_W-1:0] c, input step_t s);
        return !((s == STEP_DEC) && (c == '0));
    endfunction

    // ---------------------------------------------------------------- registers
    state_t               state_reg, state_next;
    logic                 init_reg, init_next;
    logic [AW-1:0]        sweep_cnt_reg, sweep_cnt_next;
    logic [DIR_W-1:0]     fill_val_reg, fill_val_next;
    logic [KW-1:0]        nbr_k_reg, nbr_k_next;
    logic                 p_valid_reg, p_valid_next;
    logic [AW-1:0]        p_addr_reg, p_addr_next;
    logic [2:0]           p_k_reg, p_k_next;
    logic                 m_valid_reg, m_valid_next;

    logic [DIM_W-1:0]     grid_width_reg, grid_height_reg;
    logic                 allow_diag_reg;

    func_t                func_reg, func_next;
    logic [COORD_W-1:0]   x_reg, x_next;
    logic [COORD_W-1:0]   y_reg, y_next;
    logic [DIR_W-1:0]     bits_reg, bits_next;
    logic                 walkv_reg, walkv_next;
    logic                 err_reg, err_next;
    logic [DIR_W-1:0]     tgt_mask_reg, tgt_mask_next;
    logic                 tgt_walk_reg, tgt_walk_next;
    logic [DIR_W-1:0]     out_mask_reg, out_mask_next;
    logic                 out_walk_reg, out_walk_next;
    logic                 out_err_reg, out_err_next;

    // ---------------------------------------------------------------- memories
    logic [DIR_W-1:0]     mask_mem [DEPTH];
    logic                 walk_mem [DEPTH];
    logic [DIR_W-1:0]     mask_rd_reg;
    logic                 walk_rd_reg;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 mask_we;
    logic                 walk_we;
    logic [DIR_W-1:0]     mask_wdata;
    logic                 walk_wdata;

    always_ff @(posedge aclk) begin
        mask_rd_reg <= mask_mem[rd_addr];
        walk_rd_reg <= walk_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (mask_we) begin
            mask_mem[wr_addr] <= mask_wdata;
        end
        if (walk_we) begin
            walk_mem[wr_addr] <= walk_wdata;
        end
    end

    // ---------------------------------------------------------------- config port
    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= DIM_RESET;
            grid_height_reg <= DIM_RESET;
            allow_diag_reg  <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[DIM_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[DIM_W-1:0];
                REG_ALLOW_DIAG:  allow_diag_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(grid_height_reg);
            REG_ALLOW_DIAG:  prdata = APB_DATA_W'(allow_diag_reg);
            default:         prdata = '0;
        endcase
    end

    // Zero sizes count as one
    logic [DIM_W-1:0] w_eff, h_eff;
    assign w_eff = (grid_width_reg  == '0) ? DIM_W'(1) : grid_width_reg;
    assign h_eff = (grid_height_reg == '0) ? DIM_W'(1) : grid_height_reg;

    // ---------------------------------------------------------------- input decode
    logic [COORD_W-1:0] in_x, in_y;
    logic               in_accept;
    logic               in_err;
    logic [AW-1:0]      in_addr;
    logic [AW-1:0]      tgt_addr;

    assign in_x      = s_tdata[8:3];
    assign in_y      = s_tdata[14:9];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid & s_tready;
    assign in_err    = !(dim_ok({1'b0, in_x}, w_eff, MAX_COLS) &&
                         dim_ok({1'b0, in_y}, h_eff, MAX_ROWS));
    assign in_addr   = {YW'(in_y), XW'(in_x)};
    assign tgt_addr  = {YW'(y_reg), XW'(x_reg)};

    // ---------------------------------------------------------------- neighbour walk
    logic [2:0]       k3;
    step_t            nbr_dx, nbr_dy;
    logic [DIM_W-1:0] nx7, ny7;
    logic             nbr_ok;
    logic [AW-1:0]    nbr_addr;

    assign k3       = nbr_k_reg[2:0];
    assign nbr_dx   = NBR_DX[k3];
    assign nbr_dy   = NBR_DY[k3];
    assign nx7      = step_coord({1'b0, x_reg}, nbr_dx);
    assign ny7      = step_coord({1'b0, y_reg}, nbr_dy);
    assign nbr_ok   = (nbr_k_reg < KW'(NBR_COUNT)) &&
                      (!NBR_DIAG[k3] || allow_diag_reg) &&
                      step_ok({1'b0, x_reg}, nbr_dx) && step_ok({1'b0, y_reg}, nbr_dy) &&
                      dim_ok(nx7, w_eff, MAX_COLS) && dim_ok(ny7, h_eff, MAX_ROWS);
    assign nbr_addr = {YW'(ny7), XW'(nx7)};

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next     = state_reg;
        init_next      = init_reg;
        sweep_cnt_next = sweep_cnt_reg;
        fill_val_next  = fill_val_reg;
        nbr_k_next     = nbr_k_reg;
        p_valid_next   = p_valid_reg;
        p_addr_next    = p_addr_reg;
        p_k_next       = p_k_reg;
        m_valid_next   = m_valid_reg;
        func_next      = func_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        bits_next      = bits_reg;
        walkv_next     = walkv_reg;
        err_next       = err_reg;
        tgt_mask_next  = tgt_mask_reg;
        tgt_walk_next  = tgt_walk_reg;
        out_mask_next  = out_mask_reg;
        out_walk_next  = out_walk_reg;
        out_err_next   = out_err_reg;

        rd_addr    = tgt_addr;
        wr_addr    = tgt_addr;
        mask_we    = 1'b0;
        walk_we    = 1'b0;
        mask_wdata = tgt_mask_reg;
        walk_wdata = tgt_walk_reg;

        // Drop the result once it has been taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_SWEEP: begin
                wr_addr        = sweep_cnt_reg;
                mask_we        = 1'b1;
                mask_wdata     = fill_val_reg;
                walk_we        = init_reg;
                walk_wdata     = 1'b1;
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (&sweep_cnt_reg) begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end
            end

            ST_IDLE: begin
                // Read the target while the item is latched
                rd_addr = in_addr;
                if (in_accept) begin
                    func_next  = func_t'(s_tdata[2:0]);
                    x_next     = in_x;
                    y_next     = in_y;
                    bits_next  = s_tdata[22:15];
                    walkv_next = s_tdata[23];
                    err_next   = in_err;
                    state_next = in_err ? ST_DONE : ST_TGT;
                end
            end

            ST_TGT: begin
                tgt_mask_next = mask_rd_reg;
                tgt_walk_next = walk_rd_reg;
                nbr_k_next    = '0;
                p_valid_next  = 1'b0;
                state_next    = ST_DONE;
                case (func_reg)
                    FUNC_OPEN: begin
                        tgt_walk_next = 1'b1;
                        state_next    = ST_NBR;
                    end
                    FUNC_CLOSE: begin
                        tgt_mask_next = MASK_NONE;
                        tgt_walk_next = 1'b0;
                        state_next    = ST_NBR;
                    end
                    FUNC_OR_MASK: begin
                        tgt_mask_next = mask_rd_reg | bits_reg;
                        mask_we       = 1'b1;
                        mask_wdata    = mask_rd_reg | bits_reg;
                    end
                    FUNC_CLR_MASK: begin
                        tgt_mask_next = mask_rd_reg & ~bits_reg;
                        mask_we       = 1'b1;
                        mask_wdata    = mask_rd_reg & ~bits_reg;
                    end
                    FUNC_SET_WALK: begin
                        tgt_walk_next = walkv_reg;
                        walk_we       = 1'b1;
                        walk_wdata    = walkv_reg;
                    end
                    FUNC_FILL_ALL: begin
                        tgt_mask_next  = MASK_ALL;
                        fill_val_next  = MASK_ALL;
                        sweep_cnt_next = '0;
                        state_next     = ST_SWEEP;
                    end
                    FUNC_CLEAR_ALL: begin
                        tgt_mask_next  = MASK_NONE;
                        fill_val_next  = MASK_NONE;
                        sweep_cnt_next = '0;
                        state_next     = ST_SWEEP;
                    end
                    default: ;
                endcase
            end

            ST_NBR: begin
                // Read neighbour k while writing back neighbour k-1
                rd_addr      = nbr_addr;
                p_valid_next = nbr_ok;
                p_addr_next  = nbr_addr;
                p_k_next     = k3;
                nbr_k_next   = nbr_k_reg + 1'b1;
                wr_addr      = p_addr_reg;
                if (p_valid_reg) begin
                    if (func_reg == FUNC_OPEN) begin
                        if (walk_rd_reg) begin
                            mask_we       = 1'b1;
                            mask_wdata    = mask_rd_reg | NBR_BACK[p_k_reg];
                            tgt_mask_next = tgt_mask_reg | NBR_OWN[p_k_reg];
                        end
                    end else begin
                        mask_we    = 1'b1;
                        mask_wdata = mask_rd_reg & ~NBR_BACK[p_k_reg];
                    end
                end
                if (nbr_k_reg == KW'(NBR_COUNT)) begin
                    state_next = ST_WB;
                end
            end

            ST_WB: begin
                mask_we    = 1'b1;
                walk_we    = 1'b1;
                state_next = ST_DONE;
            end

            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    out_mask_next = err_reg ? MASK_NONE : tgt_mask_reg;
                    out_walk_next = err_reg ? 1'b0 : tgt_walk_reg;
                    out_err_next  = err_reg;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            init_reg      <= 1'b1;
            sweep_cnt_reg <= '0;
            fill_val_reg  <= MASK_ALL;
            nbr_k_reg     <= '0;
            p_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            sweep_cnt_reg <= sweep_cnt_next;
            fill_val_reg  <= fill_val_next;
            nbr_k_reg     <= nbr_k_next;
            p_valid_reg   <= p_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_addr_reg   <= p_addr_next;
        p_k_reg      <= p_k_next;
        func_reg     <= func_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        bits_reg     <= bits_next;
        walkv_reg    <= walkv_next;
        err_reg      <= err_next;
        tgt_mask_reg <= tgt_mask_next;
        tgt_walk_reg <= tgt_walk_next;
        out_mask_reg <= out_mask_next;
        out_walk_reg <= out_walk_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, out_err_reg, out_walk_reg, out_mask_reg};

endmodule

### hdl/gcmu_checker.sv
// Port-level checks for the grid connectivity map unit, bound to the top level.
`include "grid_connectivity_map_unit_defines.svh"

module gcmu_checker
    import gcmu_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic                  pready,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata
);

    // A stalled result holds
    `GCMU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // A coordinate error carries an empty cell (error flag at bit 9)
    `GCMU_ASSERT_NOW(a_err_zero, m_tvalid && m_tdata[9], m_tdata[8:0] == 9'd0, "error result with cell data")

    // One item at a time: the input closes right after an acceptance
    `GCMU_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item accepted while busy")

    // A grid width write reads back on the next cycle
    `GCMU_ASSERT_NOW(a_width_rb, (psel && penable && pwrite && pready && paddr[3:2] == REG_GRID_WIDTH) ##1 (paddr[3:2] == REG_GRID_WIDTH), prdata[6:0] == $past(pwdata[6:0]), "grid width read-back mismatch")

endmodule

bind grid_connectivity_map_unit gcmu_checker u_gcmu_checker (.*);
